FILE: rtl/rtlpm_pkg.sv
// ----------------------------------------------------------------------------
// rtlpm_pkg
// shared types, codes and the path preference function for the route table
// ----------------------------------------------------------------------------
package rtlpm_pkg;

  localparam logic [2:0] KIND_INSERT     = 3'd0;
  localparam logic [2:0] KIND_WITHDRAW   = 3'd1;
  localparam logic [2:0] KIND_LOOKUP_ANY = 3'd2;
  localparam logic [2:0] KIND_LOOKUP_ONE = 3'd3;
  localparam logic [2:0] KIND_DISCARD    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [5:0]  MAX_LEN          = 6'd32;
  localparam logic [31:0] DFLT_PREF_RESET  = 32'd100;

  localparam logic [1:0] CMP_WORSE  = 2'd0;
  localparam logic [1:0] CMP_BETTER = 2'd1;
  localparam logic [1:0] CMP_TIE    = 2'd2;

  typedef struct packed {
    logic [31:0]        prefix;
    logic [5:0]         len;
    logic [31:0]        router;
    logic [31:0]        hop;
    logic signed [31:0] weight;
    logic [31:0]        pref;
    logic               ibgp;
    logic [15:0]        aspl;
    logic [1:0]         origin;
    logic [31:0]        oas;
    logic [31:0]        med;
  } ent_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic [31:0] rid;
  } qry_t;

  typedef struct packed {
    logic wr;
    logic clr;
  } cmt_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= MAX_LEN) begin
      m = '1;
    end else begin
      m = 32'hFFFF_FFFF << (MAX_LEN - len);
    end
    return m;
  endfunction

  // attribute order before update number and router id
  function automatic logic [1:0] path_cmp(input ent_t a, input ent_t b,
                                          input logic [31:0] dflt);
    logic [31:0] pa;
    logic [31:0] pb;
    logic [1:0]  r;
    pa = (a.pref == 32'd0) ? dflt : a.pref;
    pb = (b.pref == 32'd0) ? dflt : b.pref;
    if (a.ibgp != b.ibgp) begin
      r = a.ibgp ? CMP_WORSE : CMP_BETTER;
    end else if (a.weight != b.weight) begin
      r = (a.weight > b.weight) ? CMP_BETTER : CMP_WORSE;
    end else if (pa != pb) begin
      r = (pa > pb) ? CMP_BETTER : CMP_WORSE;
    end else if (a.aspl != b.aspl) begin
      r = (a.aspl < b.aspl) ? CMP_BETTER : CMP_WORSE;
    end else if (a.origin != b.origin) begin
      r = (a.origin < b.origin) ? CMP_BETTER : CMP_WORSE;
    end else if (a.oas == b.oas && a.med != b.med) begin
      r = (a.med < b.med) ? CMP_BETTER : CMP_WORSE;
    end else begin
      r = CMP_TIE;
    end
    return r;
  endfunction

endpackage

FILE: rtl/rtlpm_cell.sv
// ----------------------------------------------------------------------------
// rtlpm_cell
// one table slot; updates the passing scan token and hands it on
// ----------------------------------------------------------------------------
module rtlpm_cell import rtlpm_pkg::*; #(
  parameter int unsigned IW = 8,
  parameter int unsigned UB = 48,
  parameter logic [IW-1:0] CELL_IDX = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   dflt_pref_i,
  input  cmt_t          cmt_i,
  input  logic [IW-1:0] cmt_slot_i,
  input  ent_t          cmt_ent_i,
  input  logic [UB-1:0] cmt_upd_i,
  input  logic          tok_v_i,
  input  qry_t          qry_i,
  input  logic          best_v_i,
  input  ent_t          best_i,
  input  logic [UB-1:0] best_upd_i,
  input  logic          hit_v_i,
  input  logic [IW-1:0] hit_idx_i,
  input  logic          free_v_i,
  input  logic [IW-1:0] free_idx_i,
  output logic          tok_v_o,
  output qry_t          qry_o,
  output logic          best_v_o,
  output ent_t          best_o,
  output logic [UB-1:0] best_upd_o,
  output logic          hit_v_o,
  output logic [IW-1:0] hit_idx_o,
  output logic          free_v_o,
  output logic [IW-1:0] free_idx_o
);

  logic          valid_q;
  ent_t          ent_q;
  logic [UB-1:0] upd_q;

  logic          tok_v_q;
  qry_t          qry_q;
  logic          best_v_q;
  ent_t          best_q;
  logic [UB-1:0] best_upd_q;
  logic          hit_v_q;
  logic [IW-1:0] hit_idx_q;
  logic          free_v_q;
  logic [IW-1:0] free_idx_q;

  logic        sel;
  logic        is_lookup;
  logic [31:0] mask;
  logic        match;
  logic [1:0]  cmp;
  logic        better;
  logic        take;
  logic        hit;
  logic        drop;

  assign sel       = (cmt_slot_i == CELL_IDX);
  assign is_lookup = (qry_i.kind == KIND_LOOKUP_ANY) || (qry_i.kind == KIND_LOOKUP_ONE);
  assign mask      = prefix_mask(ent_q.len);
  assign match     = valid_q && is_lookup &&
                     ((qry_i.kind != KIND_LOOKUP_ONE) || (ent_q.router == qry_i.rid)) &&
                     ((qry_i.addr & mask) == (ent_q.prefix & mask));
  assign cmp       = path_cmp(ent_q, best_i, dflt_pref_i);
  assign better    = (cmp == CMP_BETTER) ||
                     ((cmp == CMP_TIE) && ((upd_q > best_upd_i) ||
                      ((upd_q == best_upd_i) && (ent_q.router < best_i.router))));
  assign take      = match && (!best_v_i || (ent_q.len > best_i.len) ||
                     ((ent_q.len == best_i.len) && better));
  assign hit       = valid_q && (ent_q.prefix == qry_i.addr) &&
                     (ent_q.len == qry_i.plen) && (ent_q.router == qry_i.rid);
  assign drop      = tok_v_i && (qry_i.kind == KIND_DISCARD) && valid_q &&
                     (ent_q.router == qry_i.rid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_v_q <= 1'b0;
    end else begin
      tok_v_q <= tok_v_i;
      if (cmt_i.wr && sel) begin
        valid_q <= 1'b1;
      end else if ((cmt_i.clr && sel) || drop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmt_i.wr && sel) begin
      ent_q <= cmt_ent_i;
      upd_q <= cmt_upd_i;
    end
    qry_q      <= qry_i;
    best_v_q   <= best_v_i || take;
    best_q     <= take ? ent_q : best_i;
    best_upd_q <= take ? upd_q : best_upd_i;
    hit_v_q    <= hit_v_i || hit;
    hit_idx_q  <= (!hit_v_i && hit) ? CELL_IDX : hit_idx_i;
    free_v_q   <= free_v_i || !valid_q;
    free_idx_q <= (!free_v_i && !valid_q) ? CELL_IDX : free_idx_i;
  end

  assign tok_v_o    = tok_v_q;
  assign qry_o      = qry_q;
  assign best_v_o   = best_v_q;
  assign best_o     = best_q;
  assign best_upd_o = best_upd_q;
  assign hit_v_o    = hit_v_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_v_o   = free_v_q;
  assign free_idx_o = free_idx_q;

endmodule

FILE: rtl/route_table_lpm_best_path.sv
// ----------------------------------------------------------------------------
// route_table_lpm_best_path
// ipv4 route table with longest prefix match and bgp best path choice
// ----------------------------------------------------------------------------
// Every item runs a scan token down a chain of DEPTH cells, one cell per
// cycle, each cell holding one route; the token passes the launch register,
// the cell registers, then capture and commit, after which the result is
// registered. One item is handled at a time, so no new item is taken until
// the last result has been committed; a result left waiting holds off the
// next item. Inserts and withdraws are written back in the commit cycle,
// discards clear matching cells as the token passes. Reset empties the table
// at once.
module route_table_lpm_best_path import rtlpm_pkg::*; #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned UPDATE_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [31:0]        addr_i,
  input  logic [5:0]         prefix_len_i,
  input  logic [31:0]        router_id_i,
  input  logic [31:0]        next_hop_i,
  input  logic signed [31:0] weight_i,
  input  logic [31:0]        local_pref_i,
  input  logic               is_ibgp_i,
  input  logic [15:0]        as_path_len_i,
  input  logic [1:0]         origin_i,
  input  logic [31:0]        origin_as_i,
  input  logic [31:0]        med_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        found_next_hop_o,
  output logic [5:0]         found_len_o,
  output logic [31:0]        found_router_o,
  output logic [47:0]        found_update_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UB = UPDATE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] dflt_q;
  logic        launch_q;
  logic [UB-1:0] cnt_q;
  logic [UB-1:0] cnt_inc;

  qry_t  qry_q;
  ent_t  ins_q;

  logic          fin_best_v_q;
  ent_t          fin_best_q;
  logic [UB-1:0] fin_upd_q;
  logic          fin_hit_v_q;
  logic [IW-1:0] fin_hit_q;
  logic          fin_free_v_q;
  logic [IW-1:0] fin_free_q;

  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] hop_q;
  logic [5:0]  len_q;
  logic [31:0] router_q;
  logic [47:0] fupd_q;

  logic          in_acc;
  logic          fire;
  cmt_t          cmt;
  logic [IW-1:0] cmt_slot;
  logic [1:0]    res_status;
  logic [47:0]   res_upd;
  logic          res_found;

  logic          tok_v    [DEPTH+1];
  qry_t          tok_qry  [DEPTH+1];
  logic          tok_bv   [DEPTH+1];
  ent_t          tok_best [DEPTH+1];
  logic [UB-1:0] tok_bupd [DEPTH+1];
  logic          tok_hv   [DEPTH+1];
  logic [IW-1:0] tok_hidx [DEPTH+1];
  logic          tok_fv   [DEPTH+1];
  logic [IW-1:0] tok_fidx [DEPTH+1];

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : dflt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= DFLT_PREF_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      dflt_q <= pwdata;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_v[DEPTH]) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qry_q.kind  <= kind_i;
      qry_q.addr  <= addr_i;
      qry_q.plen  <= prefix_len_i;
      qry_q.rid   <= router_id_i;
      ins_q.prefix <= addr_i;
      ins_q.len    <= prefix_len_i;
      ins_q.router <= router_id_i;
      ins_q.hop    <= next_hop_i;
      ins_q.weight <= weight_i;
      ins_q.pref   <= local_pref_i;
      ins_q.ibgp   <= is_ibgp_i;
      ins_q.aspl   <= as_path_len_i;
      ins_q.origin <= origin_i;
      ins_q.oas    <= origin_as_i;
      ins_q.med    <= med_i;
    end
    if ((state_q == S_SCAN) && tok_v[DEPTH]) begin
      fin_best_v_q <= tok_bv[DEPTH];
      fin_best_q   <= tok_best[DEPTH];
      fin_upd_q    <= tok_bupd[DEPTH];
      fin_hit_v_q  <= tok_hv[DEPTH];
      fin_hit_q    <= tok_hidx[DEPTH];
      fin_free_v_q <= tok_fv[DEPTH];
      fin_free_q   <= tok_fidx[DEPTH];
    end
  end

  // scan chain
  assign tok_v[0]    = launch_q;
  assign tok_qry[0]  = qry_q;
  assign tok_bv[0]   = 1'b0;
  assign tok_best[0] = '0;
  assign tok_bupd[0] = '0;
  assign tok_hv[0]   = 1'b0;
  assign tok_hidx[0] = '0;
  assign tok_fv[0]   = 1'b0;
  assign tok_fidx[0] = '0;

  ent_t cmt_ent;
  always_comb begin
    cmt_ent      = ins_q;
    cmt_ent.pref = (ins_q.pref == 32'd0) ? dflt_q : ins_q.pref;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rtlpm_cell #(
      .IW       (IW),
      .UB       (UB),
      .CELL_IDX (IW'(g))
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .dflt_pref_i (dflt_q),
      .cmt_i       (cmt),
      .cmt_slot_i  (cmt_slot),
      .cmt_ent_i   (cmt_ent),
      .cmt_upd_i   (cnt_inc),
      .tok_v_i     (tok_v[g]),
      .qry_i       (tok_qry[g]),
      .best_v_i    (tok_bv[g]),
      .best_i      (tok_best[g]),
      .best_upd_i  (tok_bupd[g]),
      .hit_v_i     (tok_hv[g]),
      .hit_idx_i   (tok_hidx[g]),
      .free_v_i    (tok_fv[g]),
      .free_idx_i  (tok_fidx[g]),
      .tok_v_o     (tok_v[g+1]),
      .qry_o       (tok_qry[g+1]),
      .best_v_o    (tok_bv[g+1]),
      .best_o      (tok_best[g+1]),
      .best_upd_o  (tok_bupd[g+1]),
      .hit_v_o     (tok_hv[g+1]),
      .hit_idx_o   (tok_hidx[g+1]),
      .free_v_o    (tok_fv[g+1]),
      .free_idx_o  (tok_fidx[g+1])
    );
  end

  // counter skips zero
  always_comb begin
    cnt_inc = cnt_q + UB'(1);
    if (cnt_inc == '0) begin
      cnt_inc = UB'(1);
    end
  end

  // result and commit
  always_comb begin
    res_status = ST_OK;
    res_upd    = '0;
    res_found  = 1'b0;
    cmt        = '0;
    cmt_slot   = fin_hit_v_q ? fin_hit_q : fin_free_q;
    case (qry_q.kind)
      KIND_INSERT: begin
        if (qry_q.plen > MAX_LEN) begin
          res_status = ST_INVALID;
        end else if (!fin_hit_v_q && !fin_free_v_q) begin
          res_status = ST_FULL;
        end else begin
          cmt.wr  = fire;
          res_upd = 48'(cnt_inc);
        end
      end
      KIND_WITHDRAW: begin
        if (qry_q.plen > MAX_LEN) begin
          res_status = ST_INVALID;
        end else if (!fin_hit_v_q) begin
          res_status = ST_NOTFOUND;
        end else begin
          cmt.clr = fire;
        end
      end
      KIND_LOOKUP_ANY, KIND_LOOKUP_ONE: begin
        if (fin_best_v_q) begin
          res_found = 1'b1;
          res_upd   = 48'(fin_upd_q);
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      KIND_DISCARD: res_status = ST_OK;
      default:      res_status = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_acc;
      if (cmt.wr) begin
        cnt_q <= cnt_inc;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res_status;
      hop_q    <= res_found ? fin_best_q.hop : 32'd0;
      len_q    <= res_found ? fin_best_q.len : 6'd0;
      router_q <= res_found ? fin_best_q.router : 32'd0;
      fupd_q   <= res_upd;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_next_hop_o = hop_q;
  assign found_len_o      = len_q;
  assign found_router_o   = router_q;
  assign found_update_o   = fupd_q;

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SCAN) && launch_q)
    else $error("item accepted without starting a scan");

  a_commit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmt.wr && cmt.clr))
    else $error("insert and withdraw committed together");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt.wr |=> (cnt_q != '0))
    else $error("update number zero after insert");

  a_commit_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmt.wr || cmt.clr) |-> (state_q == S_FIN) && !tok_v[0])
    else $error("commit outside finish state");

endmodule

FILE: sim/route_checker.sv
// ----------------------------------------------------------------------------
// route_checker
// watches the item and result channels and the register port of the route
// table, keeps a shadow table, predicts each result and compares it
// ----------------------------------------------------------------------------
module route_checker import rtlpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         kind_i,
  input  logic [31:0]        addr_i,
  input  logic [5:0]         prefix_len_i,
  input  logic [31:0]        router_id_i,
  input  logic [31:0]        next_hop_i,
  input  logic signed [31:0] weight_i,
  input  logic [31:0]        local_pref_i,
  input  logic               is_ibgp_i,
  input  logic [15:0]        as_path_len_i,
  input  logic [1:0]         origin_i,
  input  logic [31:0]        origin_as_i,
  input  logic [31:0]        med_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic [31:0]        found_next_hop_i,
  input  logic [5:0]         found_len_i,
  input  logic [31:0]        found_router_i,
  input  logic [47:0]        found_update_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int SLOTS = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hop;
    logic [5:0]  len;
    logic [31:0] router;
    logic [47:0] upd;
  } route_res_t;

  typedef struct {
    logic               used;
    logic [31:0]        prefix;
    logic [5:0]         len;
    logic [31:0]        router;
    logic [31:0]        hop;
    logic signed [31:0] weight;
    logic [31:0]        pref;
    logic               ibgp;
    logic [15:0]        aspl;
    logic [1:0]         origin;
    logic [31:0]        oas;
    logic [31:0]        med;
    logic [47:0]        upd;
  } shadow_route_t;

  shadow_route_t shadow[SLOTS];
  logic [47:0]   upd_count;
  logic [31:0]   dflt_pref;
  route_res_t    expected_results[$];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  function automatic logic [31:0] mask_of(input logic [5:0] l);
    if (l == 0) return 32'd0;
    if (l >= 32) return '1;
    return 32'hFFFF_FFFF << (32 - l);
  endfunction

  function automatic bit preferred(input shadow_route_t a, input shadow_route_t b);
    logic [31:0] pa;
    logic [31:0] pb;
    pa = (a.pref == 0) ? dflt_pref : a.pref;
    pb = (b.pref == 0) ? dflt_pref : b.pref;
    if (a.ibgp != b.ibgp) return !a.ibgp;
    if (a.weight != b.weight) return a.weight > b.weight;
    if (pa != pb) return pa > pb;
    if (a.aspl != b.aspl) return a.aspl < b.aspl;
    if (a.origin != b.origin) return a.origin < b.origin;
    if (a.oas == b.oas && a.med != b.med) return a.med < b.med;
    if (a.upd != b.upd) return a.upd > b.upd;
    return a.router < b.router;
  endfunction

  function automatic route_res_t route_apply();
    route_res_t r;
    int hit;
    int free_slot;
    int best;
    r = '0;
    hit = -1;
    free_slot = -1;
    best = -1;
    case (kind_i)
      KIND_INSERT, KIND_WITHDRAW: begin
        if (prefix_len_i > MAX_LEN) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow[i].used) begin
              if (hit < 0 && shadow[i].prefix == addr_i && shadow[i].len == prefix_len_i &&
                  shadow[i].router == router_id_i) hit = i;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (kind_i == KIND_WITHDRAW) begin
            if (hit < 0) r.status = ST_NOTFOUND;
            else shadow[hit].used = 1'b0;
          end else begin
            if (hit < 0) hit = free_slot;
            if (hit < 0) begin
              r.status = ST_FULL;
            end else begin
              upd_count = upd_count + 1;
              if (upd_count == 0) upd_count = 1;
              shadow[hit].used   = 1'b1;
              shadow[hit].prefix = addr_i;
              shadow[hit].len    = prefix_len_i;
              shadow[hit].router = router_id_i;
              shadow[hit].hop    = next_hop_i;
              shadow[hit].weight = weight_i;
              shadow[hit].pref   = (local_pref_i == 0) ? dflt_pref : local_pref_i;
              shadow[hit].ibgp   = is_ibgp_i;
              shadow[hit].aspl   = as_path_len_i;
              shadow[hit].origin = origin_i;
              shadow[hit].oas    = origin_as_i;
              shadow[hit].med    = med_i;
              shadow[hit].upd    = upd_count;
              r.upd = upd_count;
            end
          end
        end
      end
      KIND_LOOKUP_ANY, KIND_LOOKUP_ONE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow[i].used) continue;
          if (kind_i == KIND_LOOKUP_ONE && shadow[i].router != router_id_i) continue;
          if ((addr_i & mask_of(shadow[i].len)) !=
              (shadow[i].prefix & mask_of(shadow[i].len))) continue;
          if (best < 0 || shadow[i].len > shadow[best].len ||
              (shadow[i].len == shadow[best].len && preferred(shadow[i], shadow[best])))
            best = i;
        end
        if (best < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.hop    = shadow[best].hop;
          r.len    = shadow[best].len;
          r.router = shadow[best].router;
          r.upd    = shadow[best].upd;
        end
      end
      KIND_DISCARD: begin
        for (int i = 0; i < SLOTS; i++)
          if (shadow[i].used && shadow[i].router == router_id_i) shadow[i].used = 1'b0;
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    route_res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) shadow[i].used = 1'b0;
      upd_count = '0;
      dflt_pref = DFLT_PREF_RESET;
      expected_results.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 3'd0) dflt_pref = pwdata;
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", 64'(status_i), 64'd0);
        end else begin
          e = expected_results.pop_front();
          if (status_i != e.status) report_mismatch("status", 64'(status_i), 64'(e.status));
          if (found_next_hop_i != e.hop)
            report_mismatch("next hop", 64'(found_next_hop_i), 64'(e.hop));
          if (found_len_i != e.len) report_mismatch("len", 64'(found_len_i), 64'(e.len));
          if (found_router_i != e.router)
            report_mismatch("router", 64'(found_router_i), 64'(e.router));
          if (found_update_i != e.upd)
            report_mismatch("update", 64'(found_update_i), 64'(e.upd));
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(route_apply());
    end
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// random and directed route table traffic with idle and stall phases; the
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
  import rtlpm_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         kind_i;
  logic [31:0]        addr_i;
  logic [5:0]         prefix_len_i;
  logic [31:0]        router_id_i;
  logic [31:0]        next_hop_i;
  logic signed [31:0] weight_i;
  logic [31:0]        local_pref_i;
  logic               is_ibgp_i;
  logic [15:0]        as_path_len_i;
  logic [1:0]         origin_i;
  logic [31:0]        origin_as_i;
  logic [31:0]        med_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [31:0]        found_next_hop_o;
  logic [5:0]         found_len_o;
  logic [31:0]        found_router_o;
  logic [47:0]        found_update_o;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 hold_off;
  logic [31:0]        routers[4];
  logic [31:0]        prefixes[8];

  route_table_lpm_best_path DUT (.*);

  route_checker u_checker (
    .in_ready_i(in_ready_o), .out_valid_i(out_valid_o), .status_i(status_o),
    .found_next_hop_i(found_next_hop_o), .found_len_i(found_len_o),
    .found_router_i(found_router_o), .found_update_i(found_update_o),
    .fail_count_o(fail_count), .pending_o(pending), .*
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #300_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_route(input logic [2:0] k, input logic [31:0] a, input logic [5:0] l,
                            input logic [31:0] rid);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    addr_i        <= a;
    prefix_len_i  <= l;
    router_id_i   <= rid;
    next_hop_i    <= $urandom;
    weight_i      <= ($urandom_range(3) == 0) ? $urandom : $urandom_range(2);
    local_pref_i  <= ($urandom_range(2) == 0) ? 32'd0 :
                     (($urandom_range(3) == 0) ? $urandom : $urandom_range(200));
    is_ibgp_i     <= $urandom_range(1);
    as_path_len_i <= ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    origin_i      <= $urandom_range(3) == 0 ? 2'd3 : $urandom_range(2);
    origin_as_i   <= $urandom_range(1);
    med_i         <= ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [2:0]  k;
    logic [5:0]  l;
    logic [31:0] a;
    int          p;
    p = $urandom_range(99);
    if (p < 40) k = KIND_INSERT;
    else if (p < 52) k = KIND_WITHDRAW;
    else if (p < 75) k = KIND_LOOKUP_ANY;
    else if (p < 92) k = KIND_LOOKUP_ONE;
    else if (p < 96) k = KIND_DISCARD;
    else k = 3'($urandom_range(7));
    l = ($urandom_range(19) == 0) ? 6'($urandom) : 6'($urandom_range(32));
    a = ($urandom_range(4) == 0) ? $urandom : prefixes[$urandom_range(7)] ^ $urandom_range(255);
    if (k == KIND_INSERT || k == KIND_WITHDRAW)
      a = a & (32'hFFFF_FFFF << (32 - ((l > 6'd32) ? 32 : int'(l))));
    send_route(k, a, l, ($urandom_range(9) == 0) ? $urandom : routers[$urandom_range(3)]);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; kind_i = '0; addr_i = '0; prefix_len_i = '0; router_id_i = '0;
    next_hop_i = '0; weight_i = '0; local_pref_i = '0; is_ibgp_i = 1'b0;
    as_path_len_i = '0; origin_i = '0; origin_as_i = '0; med_i = '0;
    out_ready_i = 1'b1; hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    routers = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0A00_0001};
    prefixes = '{32'h0, 32'h0A00_0000, 32'hC0A8_0100, 32'hFFFF_FFFF,
                 32'h0A01_0000, 32'h8000_0000, 32'hAC10_0000, 32'h0A00_0100};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and special cases
    send_route(KIND_LOOKUP_ANY, 32'h0, 6'd0, 32'd0);
    send_route(KIND_WITHDRAW, 32'h0A00_0000, 6'd8, 32'd1);
    send_route(KIND_INSERT, 32'h0, 6'd0, 32'd0);
    send_route(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
    send_route(KIND_INSERT, 32'h0A00_0000, 6'd8, 32'd1);
    send_route(KIND_INSERT, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF);
    send_route(KIND_INSERT, 32'h0A00_0000, 6'd8, 32'd1);
    send_route(KIND_INSERT, 32'h0, 6'd33, 32'd1);
    send_route(KIND_WITHDRAW, 32'h0, 6'd63, 32'd1);
    send_route(KIND_LOOKUP_ANY, 32'h0A01_0203, 6'd63, 32'd0);
    send_route(KIND_LOOKUP_ONE, 32'h0A01_0203, 6'd0, 32'hFFFF_FFFF);
    send_route(KIND_LOOKUP_ANY, 32'hFFFF_FFFF, 6'd0, 32'd0);
    send_route(KIND_LOOKUP_ONE, 32'h0B00_0000, 6'd0, 32'd5);
    send_route(3'd5, 32'h0, 6'd0, 32'd0);
    send_route(3'd6, 32'h0, 6'd0, 32'd0);
    send_route(3'd7, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
    send_route(KIND_WITHDRAW, 32'h0A00_0000, 6'd8, 32'd1);
    send_route(KIND_DISCARD, 32'h0, 6'd0, 32'd1234);
    send_route(KIND_DISCARD, 32'h0, 6'd0, 32'hFFFF_FFFF);
    send_route(KIND_LOOKUP_ANY, 32'h0A00_0001, 6'd0, 32'd0);
    drain();

    // fill the table to exercise the full case
    for (int i = 0; i < 258; i++) send_route(KIND_INSERT, 32'(i) << 8, 6'd24, 32'd7);
    send_route(KIND_LOOKUP_ONE, 32'h0000_0510, 6'd0, 32'd7);
    send_route(KIND_DISCARD, 32'h0, 6'd0, 32'd7);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin reg_write(32'd0); send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin reg_write(32'hFFFF_FFFF); send_idle_pct = 74; recv_stall_pct = 0; end
        2: begin reg_write(32'd150); send_idle_pct = 0; recv_stall_pct = 74; end
        3: begin reg_write($urandom); send_idle_pct = 38; recv_stall_pct = 38; end
        default: begin reg_write(32'd100); send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) hold_off <= 2000;
      for (int n = 0; n < 55; n++) random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
